>>> src/tlsa_pkg.sv
// ----------------------------------------------------------------------------
// tlsa_pkg: shared types and constants for the SARA AM reorder block
// Code point widths, character codes, command and state types used by the
// front classifier, the command queue and the back sequencer.
// ----------------------------------------------------------------------------
package tlsa_pkg;

  localparam int CODE_W        = 21;
  localparam int DATA_W        = 24;
  localparam int RUN_DEPTH_DEF = 16;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [CODE_W-1:0] LAO_BIT    = 21'h00080;
  localparam logic [CODE_W-1:0] SARA_AM    = 21'h00E33;
  localparam logic [CODE_W-1:0] MAI_HAN    = 21'h00E31;
  localparam logic [CODE_W-1:0] VOWEL_LO   = 21'h00E34;
  localparam logic [CODE_W-1:0] VOWEL_HI   = 21'h00E37;
  localparam logic [CODE_W-1:0] TONE_LO    = 21'h00E47;
  localparam logic [CODE_W-1:0] TONE_HI    = 21'h00E4E;
  // nikhahit sits 0x1A above SARA AM, SARA AA one below
  localparam logic [CODE_W-1:0] NIKHAHIT_OFS = 21'h0001A;

  typedef enum logic [1:0] {
    KIND_OTHER,
    KIND_AM,
    KIND_TONE
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [CODE_W-1:0] code;
    logic              last;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEAD,
    ST_READ,
    ST_MARK,
    ST_TAIL,
    ST_EVICT_RD,
    ST_EVICT,
    ST_PUSH
  } state_e;

endpackage

>>> src/tlsa_front.sv
// ----------------------------------------------------------------------------
// tlsa_front: input classifier
// Sorts each incoming code point into SARA AM, held mark or other character
// and hands the command to the queue.
// ----------------------------------------------------------------------------
module tlsa_front (
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [tlsa_pkg::DATA_W-1:0] s_axis_tdata_i,  // [20:0] code_point
  input  logic                        s_axis_tlast_i,  // end_of_text
  output logic                        push_valid_o,
  input  logic                        push_ready_i,
  output tlsa_pkg::cmd_t              push_cmd_o
);
  import tlsa_pkg::*;

  logic [CODE_W-1:0] cp;
  logic [CODE_W-1:0] base;
  logic              is_am;
  logic              is_tone;

  assign cp   = s_axis_tdata_i[CODE_W-1:0];
  // fold Lao onto the Thai block
  assign base = cp & ~LAO_BIT;

  assign is_am   = (base == SARA_AM);
  assign is_tone = (base == MAI_HAN) ||
                   ((base >= VOWEL_LO) && (base <= VOWEL_HI)) ||
                   ((base >= TONE_LO) && (base <= TONE_HI));

  always_comb begin
    push_cmd_o.code = cp;
    push_cmd_o.last = s_axis_tlast_i;
    if (is_am) begin
      push_cmd_o.kind = KIND_AM;
    end else if (is_tone) begin
      push_cmd_o.kind = KIND_TONE;
    end else begin
      push_cmd_o.kind = KIND_OTHER;
    end
  end

  assign push_valid_o    = s_axis_tvalid_i;
  assign s_axis_tready_o = push_ready_i;

endmodule

>>> src/tlsa_queue.sv
// ----------------------------------------------------------------------------
// tlsa_queue: command queue
// Small FIFO between classifier and sequencer so either side can stall.
// ----------------------------------------------------------------------------
module tlsa_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  tlsa_pkg::cmd_t push_cmd_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output tlsa_pkg::cmd_t pop_cmd_o
);
  import tlsa_pkg::*;

  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          slot_q [QUEUE_DEPTH];
  logic [QW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QW-1:0] rd_ptr_q, rd_ptr_d;
  logic [NW-1:0] fill_q, fill_d;
  logic          do_push;
  logic          do_pop;

  assign push_ready_o = (fill_q != NW'(QUEUE_DEPTH));
  assign pop_valid_o  = (fill_q != '0);
  assign pop_cmd_o    = slot_q[rd_ptr_q];

  assign do_push = push_valid_i && push_ready_o;
  assign do_pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

>>> src/tlsa_back.sv
// ----------------------------------------------------------------------------
// tlsa_back: run store and output sequencer
// Holds the pending mark run in a circular memory and emits the reordered
// beats for each command through a registered output stage.
// ----------------------------------------------------------------------------
module tlsa_back #(
  parameter int RUN_DEPTH = tlsa_pkg::RUN_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_valid_i,
  output logic                        cmd_ready_o,
  input  tlsa_pkg::cmd_t              cmd_i,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [tlsa_pkg::DATA_W-1:0] m_axis_tdata_o,  // [20:0] out_code
  output logic                        m_axis_tlast_o,  // last_of_run
  output logic                        m_axis_tuser_o   // text_done
);
  import tlsa_pkg::*;

  localparam int PW = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;
  localparam int CW = $clog2(RUN_DEPTH + 1);

  state_e            state_q, state_d;
  cmd_t              cmd_q, cmd_d;
  logic              final_q, final_d;
  logic [PW-1:0]     head_q, head_d;
  logic [PW-1:0]     tail_q, tail_d;
  logic [CW-1:0]     count_q, count_d;
  logic [PW-1:0]     head_inc;
  logic [PW-1:0]     tail_inc;

  logic [CODE_W-1:0] run_mem [RUN_DEPTH];
  logic [CODE_W-1:0] rd_data_q;
  logic              wr_en;

  logic              out_valid_q, out_valid_d;
  logic [CODE_W-1:0] out_code_q, out_code_d;
  logic              out_last_q, out_last_d;
  logic              out_done_q, out_done_d;
  logic              out_free;
  logic              emit;
  logic [CODE_W-1:0] emit_code;
  logic              emit_last;
  logic              emit_done;

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign head_inc = (head_q == PW'(RUN_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign tail_inc = (tail_q == PW'(RUN_DEPTH - 1)) ? '0 : tail_q + 1'b1;

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    final_d     = final_q;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    cmd_ready_o = 1'b0;
    wr_en       = 1'b0;
    emit        = 1'b0;
    emit_code   = cmd_q.code;
    emit_last   = 1'b0;
    emit_done   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        cmd_ready_o = 1'b1;
        final_d     = 1'b0;
        if (cmd_valid_i) begin
          cmd_d = cmd_i;
          case (cmd_i.kind)
            KIND_AM: state_d = ST_LEAD;
            KIND_TONE: begin
              state_d = (count_q == CW'(RUN_DEPTH)) ? ST_EVICT_RD : ST_PUSH;
            end
            default: state_d = (count_q != '0) ? ST_READ : ST_TAIL;
          endcase
        end
      end
      ST_LEAD: begin
        emit      = 1'b1;
        emit_code = cmd_q.code + NIKHAHIT_OFS;
        if (out_free) begin
          state_d = (count_q != '0) ? ST_READ : ST_TAIL;
        end
      end
      ST_READ: begin
        // wait out the memory read of the head entry
        state_d = ST_MARK;
      end
      ST_MARK: begin
        emit      = 1'b1;
        emit_code = rd_data_q;
        emit_last = final_q && (count_q == CW'(1));
        emit_done = emit_last && cmd_q.last;
        if (out_free) begin
          head_d  = head_inc;
          count_d = count_q - 1'b1;
          if (count_q == CW'(1)) begin
            state_d = final_q ? ST_IDLE : ST_TAIL;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_TAIL: begin
        emit      = 1'b1;
        emit_code = (cmd_q.kind == KIND_AM) ? cmd_q.code - 1'b1 : cmd_q.code;
        emit_last = 1'b1;
        emit_done = cmd_q.last;
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_EVICT_RD: begin
        state_d = ST_EVICT;
      end
      ST_EVICT: begin
        // run is full: drop the oldest mark out early
        emit      = 1'b1;
        emit_code = rd_data_q;
        emit_last = !cmd_q.last;
        if (out_free) begin
          head_d  = head_inc;
          count_d = count_q - 1'b1;
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        wr_en   = 1'b1;
        tail_d  = tail_inc;
        count_d = count_q + 1'b1;
        final_d = cmd_q.last;
        state_d = cmd_q.last ? ST_READ : ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase

    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_code_d  = out_code_q;
    out_last_d  = out_last_q;
    out_done_d  = out_done_q;
    if (emit && out_free) begin
      out_valid_d = 1'b1;
      out_code_d  = emit_code;
      out_last_d  = emit_last;
      out_done_d  = emit_done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      final_q     <= 1'b0;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      final_q     <= final_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    out_code_q <= out_code_d;
    out_last_q <= out_last_d;
    out_done_q <= out_done_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      run_mem[tail_q] <= cmd_q.code;
    end
    rd_data_q <= run_mem[head_q];
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(DATA_W - CODE_W){1'b0}}, out_code_q};
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_done_q;

endmodule

>>> src/thai_lao_sara_am_reorder.sv
// ----------------------------------------------------------------------------
// thai_lao_sara_am_reorder: Thai / Lao SARA AM decomposition
// Holds tone marks and moves the nikhahit of a SARA AM back over them.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one code point per beat in tdata[20:0], tlast marks the end
//   of the text. Master stream: one reordered code point per beat in
//   tdata[20:0], tlast on the final beat caused by an input beat, tuser on
//   the final beat of the whole text.
//   A tone mark produces no beat unless the run of RUN_DEPTH held marks is
//   full, in which case the oldest mark leaves at once. A SARA AM produces
//   the nikhahit, the held run, then SARA AA; any other character flushes
//   the run and passes through. End of text flushes the run.
// Flow:
//   A classified beat reaches the sequencer through a two-entry queue. The
//   sequencer takes each command in its idle state and emits direct beats
//   from its lead and tail states; each flushed or evicted mark first waits
//   in a read state for the registered read of the run memory, and each held
//   mark is written to the run memory in a push state.
// Reset clears the run count, the queue and the output stage; no clearing
// pass is needed. When the receiver stalls, the output beat holds, the
// sequencer waits and the queue fills until tready drops on the input side.
// ----------------------------------------------------------------------------
module thai_lao_sara_am_reorder #(
  parameter int RUN_DEPTH = tlsa_pkg::RUN_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [tlsa_pkg::DATA_W-1:0] s_axis_tdata_i,  // [20:0] code_point
  input  logic                        s_axis_tlast_i,  // end_of_text
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [tlsa_pkg::DATA_W-1:0] m_axis_tdata_o,  // [20:0] out_code
  output logic                        m_axis_tlast_o,  // last_of_run
  output logic                        m_axis_tuser_o   // text_done
);
  import tlsa_pkg::*;

  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_cmd;

  tlsa_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .push_valid_o    (push_valid),
    .push_ready_i    (push_ready),
    .push_cmd_o      (push_cmd)
  );

  tlsa_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  tlsa_back #(
    .RUN_DEPTH (RUN_DEPTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (pop_valid),
    .cmd_ready_o     (pop_ready),
    .cmd_i           (pop_cmd),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule

>>> src/tlsa_checker.sv
// ----------------------------------------------------------------------------
// tlsa_checker: port-level checks for the SARA AM reorder block
// Watches both stream sides of the top level over time.
// ----------------------------------------------------------------------------
module tlsa_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid_i,
  input logic                        s_axis_tready_o,
  input logic [tlsa_pkg::DATA_W-1:0] s_axis_tdata_i,
  input logic                        s_axis_tlast_i,
  input logic                        m_axis_tvalid_o,
  input logic                        m_axis_tready_i,
  input logic [tlsa_pkg::DATA_W-1:0] m_axis_tdata_o,
  input logic                        m_axis_tlast_o,
  input logic                        m_axis_tuser_o
);
  import tlsa_pkg::*;

  // a stalled beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o) &&
      $stable(m_axis_tuser_o))
    else $error("output beat changed while stalled");

  // end of text always closes the run of its input beat
  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tlast_o)
    else $error("text_done without last_of_run");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[DATA_W-1:CODE_W] == '0))
    else $error("tdata padding bits set");

  // an offered input beat and the ready answer are always known
  a_in_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i |-> !$isunknown({s_axis_tready_o, s_axis_tdata_i, s_axis_tlast_i}))
    else $error("unknown value on the input side");

  // nothing leaves right after reset
  a_reset_idle: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid_o)
    else $error("output valid right after reset");

endmodule

bind thai_lao_sara_am_reorder tlsa_checker u_tlsa_checker (.*);

>>> tb/reorder_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// reorder_checker: stream checker for the SARA AM reorder block
// Watches both stream sides. Each accepted input beat updates a private copy
// of the held tone-mark run and queues the beats the block owes for it. Each
// accepted output beat is compared with the oldest owed beat.
// ----------------------------------------------------------------------------
module reorder_checker #(
  parameter int RUN_DEPTH = tlsa_pkg::RUN_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_tvalid_i,
  input  logic                        s_tready_i,
  input  logic [tlsa_pkg::DATA_W-1:0] s_tdata_i,   // [20:0] code_point
  input  logic                        s_tlast_i,   // end_of_text
  input  logic                        m_tvalid_i,
  input  logic                        m_tready_i,
  input  logic [tlsa_pkg::DATA_W-1:0] m_tdata_i,   // [20:0] out_code
  input  logic                        m_tlast_i,   // last_of_run
  input  logic                        m_tuser_i,   // text_done
  output int                          fail_cnt_o,
  output int                          pending_o,
  output int                          in_beats_o,
  output int                          out_beats_o,
  output int                          evict_o,
  output int                          am_o
);
  import tlsa_pkg::*;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              run_end;
    logic              text_end;
  } beat_t;

  logic [CODE_W-1:0] held_marks [RUN_DEPTH];
  int unsigned       held_cnt;
  logic [CODE_W-1:0] char_beats [$];
  beat_t             due_beats [$];
  int                fails;
  int                n_in;
  int                n_out;
  int                n_evict;
  int                n_am;

  function automatic kind_e kind_of(input logic [CODE_W-1:0] cp);
    logic [CODE_W-1:0] base;
    base = cp & ~LAO_BIT;
    if (base == SARA_AM) return KIND_AM;
    if (base == MAI_HAN || (base >= VOWEL_LO && base <= VOWEL_HI) ||
        (base >= TONE_LO && base <= TONE_HI)) return KIND_TONE;
    return KIND_OTHER;
  endfunction

  // empty the held run into the beats of the current character, oldest first
  function automatic void drain_run();
    for (int i = 0; i < held_cnt; i++) char_beats.push_back(held_marks[i]);
    held_cnt = 0;
  endfunction

  task automatic reorder_char(input logic [CODE_W-1:0] cp, input logic eot);
    beat_t b;
    char_beats.delete();
    case (kind_of(cp))
      KIND_AM: begin
        n_am++;
        char_beats.push_back(cp + NIKHAHIT_OFS);
        drain_run();
        char_beats.push_back(cp - 1'b1);
      end
      KIND_TONE: begin
        if (held_cnt == RUN_DEPTH) begin
          // run full: the oldest mark leaves at once
          char_beats.push_back(held_marks[0]);
          for (int i = 1; i < RUN_DEPTH; i++) held_marks[i-1] = held_marks[i];
          held_cnt--;
          n_evict++;
        end
        held_marks[held_cnt] = cp;
        held_cnt++;
      end
      default: begin
        drain_run();
        char_beats.push_back(cp);
      end
    endcase
    if (eot) drain_run();
    foreach (char_beats[i]) begin
      b.code     = char_beats[i];
      b.run_end  = (i == char_beats.size() - 1);
      b.text_end = eot && b.run_end;
      due_beats.push_back(b);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    beat_t want;
    if (!rst_ni) begin
      held_cnt = 0;
      due_beats.delete();
      fails    = 0;
      n_in     = 0;
      n_out    = 0;
      n_evict  = 0;
      n_am     = 0;
    end else begin
      // check the output side first so a beat cannot match its own cause
      if (m_tvalid_i && m_tready_i) begin
        n_out++;
        if (due_beats.size() == 0) begin
          fails++;
          $display("%0t: unexpected beat, expected none, got code %h last %b done %b",
                   $time, m_tdata_i, m_tlast_i, m_tuser_i);
        end else begin
          want = due_beats.pop_front();
          if (m_tdata_i !== {{(DATA_W-CODE_W){1'b0}}, want.code} ||
              m_tlast_i !== want.run_end || m_tuser_i !== want.text_end) begin
            fails++;
            $display("%0t: beat mismatch, expected code %h last %b done %b,",
                     $time, want.code, want.run_end, want.text_end,
                     " got code %h last %b done %b", m_tdata_i, m_tlast_i, m_tuser_i);
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        n_in++;
        reorder_char(s_tdata_i[CODE_W-1:0], s_tlast_i);
      end
    end
    fail_cnt_o  <= fails;
    pending_o   <= due_beats.size();
    in_beats_o  <= n_in;
    out_beats_o <= n_out;
    evict_o     <= n_evict;
    am_o        <= n_am;
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the Thai / Lao SARA AM reorder block
// Sends a directed set of characters, then random texts of syllables with
// held tone-mark runs, long runs that overflow the store, and noise. Both
// stream sides stall at random; one long receiver stall backs up the input.
// The checker predicts and compares every output beat.
// ----------------------------------------------------------------------------
module tb_top;
  import tlsa_pkg::*;

  localparam int N_ITEMS      = 330;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 60;

  logic              clk_i    = 1'b0;
  logic              rst_ni   = 1'b0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata  = '0;
  logic              s_tlast  = 1'b0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [DATA_W-1:0] m_tdata;
  logic              m_tlast;
  logic              m_tuser;

  int                fail_cnt;
  int                pending;
  int                in_beats;
  int                out_beats;
  int                evicted;
  int                am_split;
  int                items_sent = 0;
  int                n_texts    = 0;
  int unsigned       cycles     = 0;
  logic              tx_quiet;
  logic              rx_quiet;

  // full speed stretches, and no idling at all near the end
  assign tx_quiet = (items_sent >= 130 && items_sent < 170) || items_sent >= N_ITEMS - 40;
  assign rx_quiet = (items_sent >= 200 && items_sent < 240) || items_sent >= N_ITEMS - 40;

  always #5 clk_i = ~clk_i;

  thai_lao_sara_am_reorder u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast),
    .m_axis_tuser_o  (m_tuser)
  );

  reorder_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_tvalid),
    .s_tready_i  (s_tready),
    .s_tdata_i   (s_tdata),
    .s_tlast_i   (s_tlast),
    .m_tvalid_i  (m_tvalid),
    .m_tready_i  (m_tready),
    .m_tdata_i   (m_tdata),
    .m_tlast_i   (m_tlast),
    .m_tuser_i   (m_tuser),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending),
    .in_beats_o  (in_beats),
    .out_beats_o (out_beats),
    .evict_o     (evicted),
    .am_o        (am_split)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still owed", cycles, pending);
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [CODE_W-1:0] pick_mark(input bit lao);
    logic [CODE_W-1:0] m;
    case ($urandom_range(0, 2))
      0:       m = MAI_HAN;
      1:       m = VOWEL_LO + CODE_W'($urandom_range(0, 3));
      default: m = TONE_LO + CODE_W'($urandom_range(0, 7));
    endcase
    return lao ? (m | LAO_BIT) : m;
  endfunction

  function automatic logic [CODE_W-1:0] pick_consonant(input bit lao);
    logic [CODE_W-1:0] c;
    c = 21'h00E01 + CODE_W'($urandom_range(0, 8'h2D));
    return lao ? (c | LAO_BIT) : c;
  endfunction

  // characters just outside the mark ranges, or SARA AM with one bit flipped
  function automatic logic [CODE_W-1:0] near_miss();
    logic [CODE_W-1:0] c;
    case ($urandom_range(0, 5))
      0:       c = MAI_HAN - 1'b1;
      1:       c = SARA_AM - 1'b1;
      2:       c = VOWEL_HI + 1'b1;
      3:       c = TONE_LO - 1'b1;
      4:       c = TONE_HI + 1'b1;
      default: c = SARA_AM ^ (21'h1 << $urandom_range(0, CODE_W - 1));
    endcase
    if ($urandom_range(0, 1)) c = c | LAO_BIT;
    return c;
  endfunction

  task automatic send_char(input logic [CODE_W-1:0] cp, input logic eot);
    if (!tx_quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    s_tdata  <= {{(DATA_W-CODE_W){1'b0}}, cp};
    s_tlast  <= eot;
    s_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    items_sent++;
  endtask

  // receiver: random stalls, plus one long hold-off once traffic is flowing
  initial begin : rx_side
    bit held_off;
    held_off = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (!held_off && items_sent >= 60) begin
        held_off = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (!rx_quiet && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      @(posedge clk_i);
    end
  end

  initial begin : tx_side
    logic [CODE_W-1:0] text_chars [$];
    int                n_words;
    int                pick;
    int                run_len;
    bit                lao;
    bit                long_done;
    long_done = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes, plain pass-through
    send_char(21'h000000, 1'b0);
    send_char(21'h1FFFFF, 1'b0);
    send_char(21'h10FFFF, 1'b0);
    // Thai syllable, marks from each range, nikhahit moves back over them
    send_char(21'h00E01, 1'b0);
    send_char(MAI_HAN, 1'b0);
    send_char(VOWEL_HI, 1'b0);
    send_char(TONE_LO, 1'b0);
    send_char(TONE_HI, 1'b0);
    send_char(SARA_AM, 1'b0);
    // same for Lao
    send_char(21'h00E81, 1'b0);
    send_char(MAI_HAN | LAO_BIT, 1'b0);
    send_char(VOWEL_LO | LAO_BIT, 1'b0);
    send_char(TONE_HI | LAO_BIT, 1'b0);
    send_char(SARA_AM | LAO_BIT, 1'b0);
    // held marks flushed by an ordinary character
    send_char(21'h00E49, 1'b0);
    send_char(21'h00E4B, 1'b0);
    send_char(21'h00E40, 1'b0);
    // end of text on a tone mark, on a bare SARA AM, and on a plain char
    send_char(21'h00E48, 1'b1);
    send_char(SARA_AM, 1'b1);
    send_char(21'h00E4A, 1'b0);
    send_char(21'h00E01, 1'b1);
    send_char(VOWEL_LO, 1'b1);
    // neighbors of the mark ranges pass through
    send_char(SARA_AM - 1'b1, 1'b0);
    send_char(VOWEL_HI + 1'b1, 1'b0);
    send_char(TONE_HI + 1'b1, 1'b1);
    n_texts = 5;

    while (items_sent < N_ITEMS) begin
      text_chars.delete();
      n_words = $urandom_range(1, 8);
      repeat (n_words) begin
        lao  = 1'($urandom_range(0, 1));
        pick = long_done ? $urandom_range(0, 99) : 0;
        if (pick < 75) begin
          text_chars.push_back(pick_consonant(lao));
          if (!long_done) run_len = RUN_DEPTH_DEF + 3;
          else if ($urandom_range(0, 19) == 0)
            run_len = $urandom_range(RUN_DEPTH_DEF - 1, RUN_DEPTH_DEF + 4);
          else run_len = $urandom_range(0, 3);
          long_done = 1'b1;
          repeat (run_len) text_chars.push_back(pick_mark(lao));
          if ($urandom_range(0, 9) < 6)
            text_chars.push_back(lao ? (SARA_AM | LAO_BIT) : SARA_AM);
        end else if (pick < 85) begin
          text_chars.push_back(near_miss());
        end else if (pick < 93) begin
          text_chars.push_back(CODE_W'($urandom_range(0, 21'h1FFFFF)));
        end else if (pick < 97) begin
          text_chars.push_back(pick_mark(lao));
        end else begin
          text_chars.push_back(lao ? (SARA_AM | LAO_BIT) : SARA_AM);
        end
      end
      foreach (text_chars[i]) send_char(text_chars[i], i == text_chars.size() - 1);
      n_texts++;
    end
    s_tvalid <= 1'b0;

    // let the owed count catch up, then watch for stray beats
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d characters in %0d texts, checked %0d reordered beats",
             in_beats, n_texts, out_beats);
    $display("split %0d SARA AM, pushed %0d marks out of a full run", am_split, evicted);
    if (fail_cnt == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
